### src/avcc_to_annexb_converter_top_defines.svh
// assertion macros for the avcc to annex-b converter
`ifndef AVCC_TO_ANNEXB_CONVERTER_TOP_DEFINES_SVH
`define AVCC_TO_ANNEXB_CONVERTER_TOP_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define AVCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold
`define AVCC_ASSERT_NEVER(lbl, cond, msg) \
  `AVCC_ASSERT(lbl, !(cond), msg)

`endif

### src/avcc_pkg.sv
// shared types and constants of the avcc to annex-b converter
package avcc_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_X_SKIP    = 4'd1,
    PH_X_LENSIZE = 4'd2,
    PH_X_SPSCNT  = 4'd3,
    PH_X_SIZEHI  = 4'd4,
    PH_X_SIZELO  = 4'd5,
    PH_X_UNIT    = 4'd6,
    PH_X_PPSCNT  = 4'd7,
    PH_X_DONE    = 4'd8,
    PH_P_LEN     = 4'd9,
    PH_P_FIRST   = 4'd10,
    PH_P_BODY    = 4'd11
  } phase_e;

  // output / prefix sequencer
  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_PFX  = 2'd1,
    SEQ_EMIT = 2'd2
  } seq_e;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PKT  = 2'd1;
  localparam logic [1:0] ST_BAD_XD   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // command codes
  localparam logic CMD_EXTRA  = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
  localparam logic [2:0] START_LONG   = 3'd4;
  localparam logic [2:0] START_SHORT  = 3'd3;
  localparam logic [2:0] PREFIX_LEN   = 3'd4;

endpackage

### src/avcc_stream_if.sv
// request and result channels of the avcc to annex-b converter
interface avcc_in_if #(parameter int SIZE_BITS = 24);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [7:0]           data_byte;
  logic                 first;
  logic [SIZE_BITS-1:0] item_size;

  modport source (output valid, command, data_byte, first, item_size, input ready);
  modport sink (input valid, command, data_byte, first, item_size, output ready);
endinterface

interface avcc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, out_bytes, byte_count, status, last, input ready);
  modport sink (input valid, out_bytes, byte_count, status, last, output ready);
endinterface

### src/avcc_to_annexb_converter_top.sv
// top level of the avcc to annex-b converter
//
// Converts length-prefixed h.264 to start-code form, one byte per input request.
// in_req_i: command (0 extradata, 1 packet), data_byte, first, item_size.
// out_res_o: up to OUT_LANE_BYTES bytes per result, first byte in bits 63..56,
// byte_count, status and last on the final result of an input request.
// Extradata units are kept behind a 00 00 00 01 prefix in a byte memory with one
// write and one read port; a fill count tracks the valid part, so reset needs no
// clearing pass.
// A request that gives no result leaves ready high. A request that gives output
// bytes is accepted, then sends one byte per cycle through the lane packer while
// the receiver does not stall; an error result carries no bytes. An idr first
// byte emits the stored set, a short or long start code and the byte
// itself. The unit size byte that opens a stored unit also has the sequencer
// write the prefix into the memory (one write port).
// Ready drops while a request is being worked off. A finished result sits in
// an output register, so the next request is taken while it waits; when the
// receiver stalls, the packer holds and ready stays low for bytes behind it.
// Reset clears all parser state, the fill count and the output valid flag.
module avcc_to_annexb_converter_top #(
  parameter int PARAM_STORE_BYTES = 256,
  parameter int SIZE_BITS         = 24,
  parameter int OUT_LANE_BYTES    = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  avcc_in_if.sink        in_req_i,
  avcc_out_if.source     out_res_o
);
  import avcc_pkg::*;

  localparam int AW = $clog2(PARAM_STORE_BYTES);
  localparam int PW = $clog2(PARAM_STORE_BYTES + 1);
  localparam int KW = $clog2(PARAM_STORE_BYTES + 6) + 1;
  localparam int LW = $clog2(OUT_LANE_BYTES + 1);
  localparam int IW = (OUT_LANE_BYTES > 1) ? $clog2(OUT_LANE_BYTES) : 1;

  // parser state
  phase_e               phase_q, phase_d;
  logic [PW-1:0]        plen_q, plen_d;
  logic [31:0]          acc_q, acc_d;
  logic [SIZE_BITS-1:0] pleft_q, pleft_d;
  logic [SIZE_BITS-1:0] nleft_q, nleft_d;
  logic                 first_nal_q, first_nal_d;
  logic [7:0]           units_q, units_d;
  logic                 pps_q, pps_d;
  logic                 drop_q, drop_d;

  // job handed from parser to sequencer
  logic                 job_go, job_pfx, job_has;
  logic [PW-1:0]        job_p, job_base;
  logic [2:0]           job_s;
  logic [1:0]           job_st;

  logic [PW-1:0]        jp_q, pbase_q;
  logic [2:0]           js_q;
  logic                 jh_q;
  logic [7:0]           jd_q;
  logic [1:0]           jst_q;
  logic [KW-1:0]        jn_q;

  // sequencer and packer
  seq_e                 seq_q, seq_d;
  logic [KW-1:0]        k_q, k_d;
  logic [LW-1:0]        lcnt_q, lcnt_d;
  logic [7:0]           lane_q [OUT_LANE_BYTES];
  logic [7:0]           lane_d [OUT_LANE_BYTES];
  logic                 go;
  logic                 seq_byte_last;
  logic [7:0]           seq_byte;
  logic [KW-1:0]        tail_idx;
  logic                 out_load;
  logic [63:0]          out_word;
  logic [3:0]           out_cnt;

  logic                 out_valid_q;
  logic [63:0]          out_bytes_q;
  logic [3:0]           out_cnt_q;
  logic [1:0]           out_st_q;
  logic                 out_last_q;

  // parameter store memory
  logic [7:0]           store_mem [PARAM_STORE_BYTES];
  logic [7:0]           mem_rd_q;
  logic                 uwe, pwe, we;
  logic [AW-1:0]        uwa, pwa, wa, rd_addr;
  logic [7:0]           pwd, wd;

  logic                 acc_in;
  logic                 cmd;
  logic [7:0]           b;

  assign in_req_i.ready = (seq_q == SEQ_IDLE);
  assign acc_in         = in_req_i.valid && in_req_i.ready;
  assign cmd            = in_req_i.command;
  assign b              = in_req_i.data_byte;

  // parser step for one accepted request
  always_comb begin
    logic       fin;
    logic       fail;
    logic [1:0] fail_st;
    phase_d     = phase_q;
    plen_d      = plen_q;
    acc_d       = acc_q;
    pleft_d     = pleft_q;
    nleft_d     = nleft_q;
    first_nal_d = first_nal_q;
    units_d     = units_q;
    pps_d       = pps_q;
    drop_d      = drop_q;
    job_go      = 1'b0;
    job_pfx     = 1'b0;
    job_has     = 1'b0;
    job_p       = '0;
    job_s       = '0;
    job_st      = ST_OK;
    job_base    = plen_q;
    uwe         = 1'b0;
    uwa         = plen_q[AW-1:0];
    fin         = 1'b0;
    fail        = 1'b0;
    fail_st     = ST_OK;
    if (acc_in) begin
      if (in_req_i.first) begin
        if (phase_q >= PH_X_SKIP && phase_q <= PH_X_PPSCNT) plen_d = '0;
        drop_d  = 1'b0;
        acc_d   = '0;
        units_d = '0;
        nleft_d = '0;
        pleft_d = in_req_i.item_size;
        if (cmd == CMD_PACKET) begin
          first_nal_d = 1'b1;
          phase_d     = PH_P_LEN;
        end else begin
          plen_d  = '0;
          pps_d   = 1'b0;
          phase_d = PH_X_SKIP;
        end
        if (pleft_d == '0) begin
          fail    = 1'b1;
          fail_st = (cmd == CMD_PACKET) ? ST_BAD_PKT : ST_BAD_XD;
          fin     = 1'b1;
        end
      end else if (phase_q == PH_IDLE || pleft_q == '0 ||
                   ((phase_q >= PH_P_LEN) != cmd)) begin
        fin = 1'b1;
      end
      if (!fin) begin
        pleft_d = pleft_d - 1'b1;
        if (drop_d) begin
          // swallow the rest of a failed item
          if (pleft_d == '0) begin
            drop_d  = 1'b0;
            phase_d = PH_IDLE;
          end
        end else if (cmd == CMD_PACKET) begin
          if (phase_d == PH_P_LEN) begin
            // nal length bytes
            if (units_d == '0) acc_d = {24'd0, b};
            else acc_d = {acc_d[23:0], b};
            units_d = units_d + 1'b1;
            if (units_d < 8'd4) begin
              if (pleft_d == '0) begin
                fail    = 1'b1;
                fail_st = ST_BAD_PKT;
              end
            end else begin
              units_d = '0;
              if (acc_d[31] || acc_d > 32'(pleft_d)) begin
                fail    = 1'b1;
                fail_st = ST_BAD_PKT;
              end else if (acc_d == '0) begin
                job_go      = 1'b1;
                job_s       = first_nal_d ? START_LONG : START_SHORT;
                first_nal_d = 1'b0;
                if (pleft_d == '0) phase_d = PH_IDLE;
              end else begin
                nleft_d = acc_d[SIZE_BITS-1:0];
                phase_d = PH_P_FIRST;
              end
            end
          end else begin
            // nal body byte, start code (and for an idr nal the stored sets) ahead of the first one
            job_go  = 1'b1;
            job_has = 1'b1;
            if (phase_d == PH_P_FIRST) begin
              if (b[4:0] == NAL_TYPE_IDR) job_p = plen_d;
              job_s       = first_nal_d ? START_LONG : START_SHORT;
              first_nal_d = 1'b0;
            end
            nleft_d = nleft_d - 1'b1;
            phase_d = PH_P_BODY;
            if (nleft_d == '0) begin
              phase_d = PH_P_LEN;
              units_d = '0;
            end
            if (pleft_d == '0) phase_d = PH_IDLE;
          end
        end else begin
          unique case (phase_d)
            PH_X_SKIP: begin
              acc_d = acc_d + 32'd1;
              if (acc_d >= 32'd4) phase_d = PH_X_LENSIZE;
            end
            PH_X_LENSIZE: phase_d = PH_X_SPSCNT;
            PH_X_SPSCNT: begin
              pps_d   = 1'b0;
              units_d = {3'd0, b[4:0]};
              phase_d = (units_d != '0) ? PH_X_SIZEHI : PH_X_PPSCNT;
            end
            PH_X_PPSCNT: begin
              pps_d   = 1'b1;
              units_d = b;
              phase_d = (units_d != '0) ? PH_X_SIZEHI : PH_X_DONE;
            end
            PH_X_SIZEHI: begin
              acc_d   = {24'd0, b};
              phase_d = PH_X_SIZELO;
            end
            PH_X_SIZELO: begin
              acc_d = {16'd0, acc_d[7:0], b};
              if (acc_d > 32'(pleft_d)) begin
                fail    = 1'b1;
                fail_st = ST_BAD_XD;
              end else if (32'(plen_d) + 32'(PREFIX_LEN) + acc_d >
                           32'(PARAM_STORE_BYTES)) begin
                fail    = 1'b1;
                fail_st = ST_OVERFLOW;
              end else begin
                // prefix is written by the sequencer in SEQ_PFX
                job_go   = 1'b1;
                job_pfx  = 1'b1;
                job_base = plen_d;
                plen_d   = plen_d + PW'(PREFIX_LEN);
                nleft_d  = acc_d[SIZE_BITS-1:0];
                if (nleft_d == '0) begin
                  units_d = units_d - 1'b1;
                  if (units_d == '0) phase_d = pps_d ? PH_X_DONE : PH_X_PPSCNT;
                  else phase_d = PH_X_SIZEHI;
                end else begin
                  phase_d = PH_X_UNIT;
                end
              end
            end
            PH_X_UNIT: begin
              uwe    = (plen_d < PW'(PARAM_STORE_BYTES));
              uwa    = plen_d[AW-1:0];
              plen_d = plen_d + 1'b1;
              nleft_d = nleft_d - 1'b1;
              if (nleft_d == '0) begin
                units_d = units_d - 1'b1;
                if (units_d == '0) phase_d = pps_d ? PH_X_DONE : PH_X_PPSCNT;
                else phase_d = PH_X_SIZEHI;
              end
            end
            default: ;
          endcase
          // blob end must fall after the last unit
          if (!fail && pleft_d == '0) begin
            if (phase_d != PH_X_DONE) begin
              fail    = 1'b1;
              fail_st = ST_BAD_XD;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
      end
      // error result, rest of the item dropped
      if (fail) begin
        job_go  = 1'b1;
        job_pfx = 1'b0;
        job_has = 1'b0;
        job_p   = '0;
        job_s   = '0;
        job_st  = fail_st;
        if (fail_st != ST_BAD_PKT) plen_d = '0;
        if (pleft_d != '0) drop_d = 1'b1;
        else phase_d = PH_IDLE;
      end
    end
  end

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: if (job_go) seq_d = job_pfx ? SEQ_PFX : SEQ_EMIT;
      SEQ_PFX:  if (k_q == KW'(PREFIX_LEN - 1)) seq_d = SEQ_IDLE;
      SEQ_EMIT: if (go && (jn_q == '0 || seq_byte_last)) seq_d = SEQ_IDLE;
      default:  seq_d = SEQ_IDLE;
    endcase
  end

  // byte source of the current result job
  assign go            = !out_valid_q || out_res_o.ready;
  assign seq_byte_last = (k_q == jn_q - 1'b1);
  assign tail_idx      = k_q - KW'(jp_q);
  always_comb begin
    if (k_q < KW'(jp_q)) seq_byte = mem_rd_q;
    else if (tail_idx < KW'(js_q)) seq_byte = (tail_idx == KW'(js_q) - 1'b1) ? 8'd1 : 8'd0;
    else seq_byte = jd_q;
  end

  // sequencer datapath: prefix writes, lane packing
  always_comb begin
    k_d      = k_q;
    lcnt_d   = lcnt_q;
    lane_d   = lane_q;
    pwe      = 1'b0;
    pwa      = AW'(pbase_q + PW'(k_q));
    pwd      = (k_q == KW'(PREFIX_LEN - 1)) ? 8'd1 : 8'd0;
    out_load = 1'b0;
    out_word = '0;
    out_cnt  = '0;
    unique case (seq_q)
      SEQ_IDLE: k_d = '0;
      SEQ_PFX: begin
        pwe = 1'b1;
        k_d = k_q + 1'b1;
      end
      SEQ_EMIT: begin
        if (go) begin
          if (jn_q == '0) begin
            out_load = 1'b1;
          end else begin
            lane_d[lcnt_q[IW-1:0]] = seq_byte;
            k_d = k_q + 1'b1;
            if (lcnt_q == LW'(OUT_LANE_BYTES - 1) || seq_byte_last) begin
              out_load = 1'b1;
              out_cnt  = 4'(lcnt_q) + 4'd1;
              for (int i = 0; i < OUT_LANE_BYTES; i++) begin
                if (LW'(i) <= lcnt_q) out_word[63 - 8*i -: 8] = lane_d[i];
              end
              lcnt_d = '0;
            end else begin
              lcnt_d = lcnt_q + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // memory port: one write, one registered read
  assign we      = uwe || pwe;
  assign wa      = uwe ? uwa : pwa;
  assign wd      = uwe ? b : pwd;
  assign rd_addr = k_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) store_mem[wa] <= wd;
    mem_rd_q <= store_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      plen_q      <= '0;
      acc_q       <= '0;
      pleft_q     <= '0;
      nleft_q     <= '0;
      first_nal_q <= 1'b1;
      units_q     <= '0;
      pps_q       <= 1'b0;
      drop_q      <= 1'b0;
      seq_q       <= SEQ_IDLE;
      k_q         <= '0;
      lcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      plen_q      <= plen_d;
      acc_q       <= acc_d;
      pleft_q     <= pleft_d;
      nleft_q     <= nleft_d;
      first_nal_q <= first_nal_d;
      units_q     <= units_d;
      pps_q       <= pps_d;
      drop_q      <= drop_d;
      seq_q       <= seq_d;
      k_q         <= k_d;
      lcnt_q      <= lcnt_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // job and result payload
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    if (seq_q == SEQ_IDLE && job_go) begin
      jp_q    <= job_p;
      js_q    <= job_s;
      jh_q    <= job_has;
      jd_q    <= b;
      jst_q   <= job_st;
      pbase_q <= job_base;
      jn_q    <= KW'(job_p) + KW'(job_s) + KW'(job_has);
    end
    if (out_load) begin
      out_bytes_q <= out_word;
      out_cnt_q   <= out_cnt;
      out_st_q    <= jst_q;
      out_last_q  <= (jn_q == '0) || seq_byte_last;
    end
  end

  assign out_res_o.valid      = out_valid_q;
  assign out_res_o.out_bytes  = out_bytes_q;
  assign out_res_o.byte_count = out_cnt_q;
  assign out_res_o.status     = out_st_q;
  assign out_res_o.last       = out_last_q;

`include "avcc_to_annexb_converter_top_defines.svh"

  `AVCC_ASSERT(a_store_fill, plen_q <= PW'(PARAM_STORE_BYTES), "store fill count overran")
  `AVCC_ASSERT_NEVER(a_write_in_emit, we && seq_q == SEQ_EMIT, "store write while emitting")
  `AVCC_ASSERT(a_lane_fill, lcnt_q < LW'(OUT_LANE_BYTES), "lane fill out of range")
  `AVCC_ASSERT(a_count_range, out_valid_q |-> out_cnt_q <= 4'(OUT_LANE_BYTES), "byte count too large")
  `AVCC_ASSERT_NEVER(a_jh_job, seq_q == SEQ_EMIT && jh_q && jn_q == '0, "data job with no bytes")

endmodule
